FILE: src/mpfb_pkg.sv
// Shared types, constants and a helper function for the page frame store plotter.
`timescale 1ns / 1ps
package mpfb_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int GRAPH_FIRST_PAGE = 1;
  localparam int GRAPH_LAST_PAGE = 7;
  localparam int GRAPH_LAST_COL = 100;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_BOX = 3'd2;
  localparam logic [2:0] CMD_FRAME = 3'd3;
  localparam logic [2:0] CMD_BITMAP = 3'd4;
  localparam logic [2:0] CMD_SHIFT = 3'd5;
  localparam logic [2:0] CMD_READ = 3'd6;
  localparam logic [2:0] CMD_NONE = 3'd7;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_INVERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] REG_DRAW_MODE = 3'd0;
  localparam logic [2:0] REG_CLIP_X_LOW = 3'd1;
  localparam logic [2:0] REG_CLIP_Y_LOW = 3'd2;
  localparam logic [2:0] REG_CLIP_X_HIGH = 3'd3;
  localparam logic [2:0] REG_CLIP_Y_HIGH = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLAN,
    ST_PIX_READ,
    ST_PIX_WAIT,
    ST_PIX_WRITE,
    ST_SHIFT_READ,
    ST_SHIFT_WAIT,
    ST_SHIFT_WRITE,
    ST_READ_WAIT,
    ST_READ_DONE,
    ST_RESULT
  } state_t;

  // One pixel operation handed from the pixel mapper to the sequencer.
  typedef struct packed {
    logic       ok;
    logic [ADDR_W-1:0] addr;
    logic [2:0] bit_idx;
    logic [1:0] mode;
  } pix_req_t;

  function automatic logic [7:0] apply_mode(input logic [7:0] b, input logic [2:0] idx,
                                            input logic [1:0] mode);
    logic [7:0] m;
    m = 8'd1 << idx;
    case (mode)
      MODE_SET: apply_mode = b | m;
      MODE_INVERT: apply_mode = b ^ m;
      MODE_CLEAR: apply_mode = b & ~m;
      default: apply_mode = b;
    endcase
  endfunction

endpackage

FILE: src/mono_page_framebuffer_plotter_unit.sv
// Top level: command sequencer around one frame store port and one pixel mapper.
// A pixel plot reads its store byte and writes it back changed, unless clipped; a read
// fetches one byte. Box, frame and bitmap commands do this read and write for each drawn
// pixel and skip the rest; shift moves bytes one at a time, clear writes every store byte.
// One item is in work at a time; a new word is taken after the result is accepted.
// Synchronous reset runs a clearing pass over every store byte before the first item.
`timescale 1ns / 1ps
module mono_page_framebuffer_plotter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  x_pos,
  input  logic [7:0]  y_pos,
  input  logic [7:0]  span_width,
  input  logic [7:0]  span_height,
  input  logic [1:0]  box_mode,
  input  logic [7:0]  bitmap_bits,
  input  logic [9:0]  read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        read_valid,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mpfb_pkg::*;

  state_t state, state_next;
  logic [7:0] mem [STORE_SIZE];
  logic [7:0] rd_q;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0] mem_wdata;
  logic mem_we;

  logic [1:0] draw_mode;
  logic [7:0] clip_x_low, clip_y_low, clip_x_high, clip_y_high;

  logic [2:0] c_cmd;
  logic [7:0] c_x, c_y, c_w, c_h, c_bits;
  logic [1:0] c_bmode;
  logic [9:0] c_raddr;
  // Walk counters: phase selects frame edge, j indexes within it, i counts box rows and shift pages.
  logic [1:0] phase;
  logic [7:0] ci, cj;
  logic [ADDR_W:0] cnt;
  logic [ADDR_W-1:0] waddr;
  logic [2:0] wbit;
  logic [1:0] wmode;
  logic [7:0] px, py;
  logic [1:0] pmode;
  logic pvalid, pdone;
  pix_req_t req;
  logic [7:0] res_data;
  logic res_rv;

  mpfb_pixel_map u_map (
    .px(px), .py(py), .mode(pmode),
    .clip_x_low(clip_x_low), .clip_y_low(clip_y_low),
    .clip_x_high(clip_x_high), .clip_y_high(clip_y_high),
    .req(req)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode <= 2'd0;
      clip_x_low <= 8'd0;
      clip_y_low <= 8'd0;
      clip_x_high <= 8'd127;
      clip_y_high <= 8'd63;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DRAW_MODE: draw_mode <= cfg_data[1:0];
        REG_CLIP_X_LOW: clip_x_low <= cfg_data;
        REG_CLIP_Y_LOW: clip_y_low <= cfg_data;
        REG_CLIP_X_HIGH: clip_x_high <= cfg_data;
        REG_CLIP_Y_HIGH: clip_y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Current pixel of the walk for each drawing command.
  always_comb begin
    px = c_x;
    py = c_y;
    pmode = draw_mode;
    pvalid = 1'b0;
    pdone = 1'b0;
    case (c_cmd)
      CMD_PIXEL: begin
        pvalid = 1'b1;
        pdone = 1'b1;
      end
      CMD_BOX: begin
        px = c_x + cj;
        py = c_y + ci;
        pmode = c_bmode;
        pvalid = (ci < c_h) && (cj < c_w);
        pdone = (ci >= c_h) || (c_w == 8'd0) ||
                ((ci == c_h - 8'd1) && (cj == c_w - 8'd1));
      end
      CMD_FRAME: begin
        case (phase)
          2'd0: begin
            px = c_x + cj;
            pvalid = c_w > 8'd1;
          end
          2'd1: begin
            px = c_x + cj;
            py = c_y + c_h - 8'd1;
            pvalid = (c_w > 8'd1) && (c_h > 8'd1);
          end
          2'd2: begin
            py = c_y + 8'd1 + cj;
            pvalid = c_h > 8'd2;
          end
          default: begin
            px = c_x + c_w - 8'd1;
            py = c_y + 8'd1 + cj;
            pvalid = (c_h > 8'd2) && (c_w > 8'd1);
          end
        endcase
        pdone = phase == 2'd3 &&
                (!((c_h > 8'd2) && (c_w > 8'd1)) || cj == c_h - 8'd3);
      end
      CMD_BITMAP: begin
        px = c_x + cj;
        if (px >= 8'(SCREEN_WIDTH)) px = px - 8'(SCREEN_WIDTH);
        pvalid = (cj < c_w) && c_bits[cj[2:0]];
        pdone = (cj == 8'd7) || (cj + 8'd1 >= c_w);
      end
      CMD_NONE: pdone = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (valid) begin
          case (cmd)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_PIXEL, CMD_BOX, CMD_FRAME, CMD_BITMAP: state_next = ST_PLAN;
            CMD_SHIFT: state_next = ST_SHIFT_READ;
            CMD_READ: state_next = ST_READ_WAIT;
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        if (cnt == (ADDR_W+1)'(STORE_SIZE - 1))
          state_next = (c_cmd == CMD_CLEAR) ? ST_RESULT : ST_IDLE;
      end
      ST_PLAN: begin
        if (pvalid && req.ok) state_next = ST_PIX_READ;
        else if (pdone) state_next = ST_RESULT;
      end
      ST_PIX_READ: state_next = ST_PIX_WAIT;
      ST_PIX_WAIT: state_next = ST_PIX_WRITE;
      ST_PIX_WRITE: state_next = ST_PLAN;
      ST_SHIFT_READ: state_next = ST_SHIFT_WAIT;
      ST_SHIFT_WAIT: state_next = ST_SHIFT_WRITE;
      ST_SHIFT_WRITE: begin
        if (ci == 8'(GRAPH_LAST_PAGE) && cj == 8'(GRAPH_LAST_COL)) state_next = ST_RESULT;
        else state_next = ST_SHIFT_READ;
      end
      ST_READ_WAIT: state_next = ST_READ_DONE;
      ST_READ_DONE: state_next = ST_RESULT;
      ST_RESULT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready = state == ST_IDLE;
    out_valid = state == ST_RESULT;
    read_data = res_data;
    read_valid = res_rv;
    mem_we = 1'b0;
    mem_addr = waddr;
    mem_wdata = 8'd0;
    case (state)
      ST_IDLE: mem_addr = read_address[ADDR_W-1:0];
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = cnt[ADDR_W-1:0];
      end
      ST_PIX_READ, ST_PIX_WAIT: mem_addr = waddr;
      ST_PIX_WRITE: begin
        mem_we = 1'b1;
        mem_wdata = apply_mode(rd_q, wbit, wmode);
      end
      ST_SHIFT_READ, ST_SHIFT_WAIT: mem_addr = waddr + ADDR_W'(1);
      ST_SHIFT_WRITE: begin
        mem_we = 1'b1;
        mem_wdata = rd_q;
      end
      ST_READ_WAIT: mem_addr = c_raddr[ADDR_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      c_cmd <= CMD_NONE;
      res_rv <= 1'b0;
      res_data <= 8'd0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          c_cmd <= cmd;
          c_x <= x_pos;
          c_y <= y_pos;
          c_w <= span_width;
          c_h <= span_height;
          c_bmode <= box_mode;
          c_bits <= bitmap_bits;
          c_raddr <= read_address;
          phase <= 2'd0;
          ci <= (cmd == CMD_SHIFT) ? 8'(GRAPH_FIRST_PAGE) : 8'd0;
          cj <= 8'd0;
          cnt <= '0;
          waddr <= ADDR_W'(GRAPH_FIRST_PAGE * SCREEN_WIDTH);
          res_rv <= cmd == CMD_READ;
          res_data <= 8'd0;
        end
        ST_CLEAR: cnt <= cnt + 1'b1;
        ST_PLAN: begin
          waddr <= req.addr;
          wbit <= req.bit_idx;
          wmode <= req.mode;
          if (!(pvalid && req.ok)) begin
            case (c_cmd)
              CMD_BOX: begin
                if (cj + 8'd1 >= c_w) begin
                  cj <= 8'd0;
                  ci <= ci + 8'd1;
                end else cj <= cj + 8'd1;
              end
              CMD_FRAME: begin
                if ((phase[1] == 1'b0 && (c_w <= 8'd1 || cj == c_w - 8'd1)) ||
                    (phase[1] == 1'b1 && (c_h <= 8'd2 || cj == c_h - 8'd3))) begin
                  cj <= 8'd0;
                  phase <= phase + 2'd1;
                end else cj <= cj + 8'd1;
              end
              default: cj <= cj + 8'd1;
            endcase
          end
        end
        ST_PIX_WRITE: begin
          case (c_cmd)
            CMD_PIXEL: c_cmd <= CMD_NONE;
            CMD_BOX: begin
              if (cj + 8'd1 >= c_w) begin
                cj <= 8'd0;
                ci <= ci + 8'd1;
              end else cj <= cj + 8'd1;
            end
            CMD_FRAME: begin
              if ((phase[1] == 1'b0 && cj == c_w - 8'd1) ||
                  (phase[1] == 1'b1 && cj == c_h - 8'd3)) begin
                cj <= 8'd0;
                phase <= phase + 2'd1;
                if (phase == 2'd3) c_cmd <= CMD_NONE;
              end else cj <= cj + 8'd1;
            end
            default: begin
              if (cj == 8'd7 || cj + 8'd1 >= c_w) c_cmd <= CMD_NONE;
              cj <= cj + 8'd1;
            end
          endcase
        end
        ST_SHIFT_WRITE: begin
          if (cj == 8'(GRAPH_LAST_COL)) begin
            cj <= 8'd0;
            ci <= ci + 8'd1;
            waddr <= ADDR_W'((32'(ci) + 32'd1) * SCREEN_WIDTH);
          end else begin
            cj <= cj + 8'd1;
            waddr <= waddr + ADDR_W'(1);
          end
        end
        ST_READ_DONE: res_data <= ({1'b0, c_raddr} < 11'(STORE_SIZE)) ? rd_q : 8'd0;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/mpfb_pixel_map.sv
// Clip test and page address computation for one pixel.
`timescale 1ns / 1ps
module mpfb_pixel_map (
  input  logic [7:0] px,
  input  logic [7:0] py,
  input  logic [1:0] mode,
  input  logic [7:0] clip_x_low,
  input  logic [7:0] clip_y_low,
  input  logic [7:0] clip_x_high,
  input  logic [7:0] clip_y_high,
  output mpfb_pkg::pix_req_t req
);
  import mpfb_pkg::*;

  logic [18:0] full_addr;

  always_comb begin
    full_addr = 19'(py >> 3) * 19'(SCREEN_WIDTH) + 19'(px);
    req.ok = (px >= clip_x_low) && (px <= clip_x_high) && (py >= clip_y_low) &&
             (py <= clip_y_high) && (full_addr < 19'(STORE_SIZE));
    req.addr = full_addr[ADDR_W-1:0];
    req.bit_idx = py[2:0];
    req.mode = mode;
  end

endmodule

FILE: src/mpfb_checker.sv
// Port-level assertions for the plotter and the bind that attaches them.
`timescale 1ns / 1ps
module mpfb_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic out_valid,
  input logic out_ready,
  input logic read_valid,
  input logic [7:0] read_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result word dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_data == 8'd0) else $error("nonzero data");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> !ready) else $error("ready after accept");
endmodule

bind mono_page_framebuffer_plotter_unit mpfb_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .out_valid(out_valid),
  .out_ready(out_ready), .read_valid(read_valid), .read_data(read_data)
);
